@@ rtl/hkt_pkg.sv @@
// Shared types and constants for the held key table.
package hkt_pkg;

    localparam int CODE_W      = 8;
    localparam int COUNT_W     = 3;
    localparam int REPORT_KEYS = 6;
    localparam int REPORT_IDX_W = 3;

    // Key codes at or below this value are invalid and never stored.
    localparam logic [CODE_W-1:0] LAST_INVALID_CODE = 8'd3;

    typedef logic [CODE_W-1:0] code_t;

    typedef enum logic [1:0] {
        KIND_PRESS    = 2'd0,
        KIND_RELEASE  = 2'd1,
        KIND_QUERY    = 2'd2,
        KIND_SET_MODS = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_SCAN   = 2'd1,
        ST_UPDATE = 2'd2,
        ST_DONE   = 2'd3
    } state_t;

    function automatic logic code_valid(input code_t code);
        return code > LAST_INVALID_CODE;
    endfunction

endpackage

@@ rtl/hkt_if.sv @@
// Handshake interfaces for the event and report channels of the held key table.
interface hkt_evt_if;
    logic                valid;
    logic                ready;
    hkt_pkg::kind_t      kind;
    logic [7:0]          key_usage;
    logic [7:0]          modifier_bits;

    modport source (output valid, output kind, output key_usage, output modifier_bits,
                    input ready);
    modport sink   (input valid, input kind, input key_usage, input modifier_bits,
                    output ready);
endinterface

interface hkt_rpt_if;
    logic       valid;
    logic       ready;
    logic       key_down;
    logic [2:0] held_count;
    logic [7:0] held_key_0;
    logic [7:0] held_key_1;
    logic [7:0] held_key_2;
    logic [7:0] held_key_3;
    logic [7:0] held_key_4;
    logic [7:0] held_key_5;
    logic [7:0] modifier_state;

    modport source (output valid, output key_down, output held_count,
                    output held_key_0, output held_key_1, output held_key_2,
                    output held_key_3, output held_key_4, output held_key_5,
                    output modifier_state, input ready);
    modport sink   (input valid, input key_down, input held_count,
                    input held_key_0, input held_key_1, input held_key_2,
                    input held_key_3, input held_key_4, input held_key_5,
                    input modifier_state, output ready);
endinterface

@@ rtl/hkt_cell.sv @@
// One slot of the key table ring; it takes its neighbour's code when the ring shifts.
module hkt_cell (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           shift,
    input  hkt_pkg::code_t din,
    output hkt_pkg::code_t dout
);

    hkt_pkg::code_t code_reg;
    hkt_pkg::code_t code_next;

    always_comb
    begin
        code_next = shift ? din : code_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_reg <= '0;
        end
        else
        begin
            code_reg <= code_next;
        end
    end

    assign dout = code_reg;

endmodule

@@ rtl/held_key_table_core.sv @@
// Top level of the held key table: slot ring, sequencer and report assembly.
//
// The block keeps up to SLOT_COUNT held key codes and a modifier byte. Each beat on
// the evt channel carries a kind (press, release, query or set modifiers), a key code
// and a modifier byte; each produces exactly one beat on the rpt channel giving
// whether the code is held afterwards, the held codes packed in slot order, their
// count and the modifier byte. Unused report positions read zero.
//
// The slots sit in a ring of cells that shifts by one position per cycle while an event
// is being worked on, so the sequencer only ever looks at the head cell. An event makes
// two laps of the ring: the first finds whether the code is already held and where the
// first empty slot is, the second applies the press or release at the head and packs
// the report. The report beat is offered once both ring laps are done. One event is in
// flight at a time and evt.ready is high only while the block is idle, so a new event
// is not accepted until the report beat of the last one has been taken.
//
// Reset empties every slot and clears the modifier byte. If the receiver stalls,
// the report beat is held steady on rpt until it is taken, and no new event is
// accepted until then.
module held_key_table_core #(
    parameter int SLOT_COUNT = 6
) (
    input  logic        clk,
    input  logic        rst_n,
    hkt_evt_if.sink     evt,
    hkt_rpt_if.source   rpt
);

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

    hkt_pkg::state_t state_reg;
    hkt_pkg::state_t state_next;

    logic [IDX_W-1:0]  step_reg;
    logic [IDX_W-1:0]  step_next;
    hkt_pkg::kind_t    kind_reg;
    hkt_pkg::kind_t    kind_next;
    hkt_pkg::code_t    code_reg;
    hkt_pkg::code_t    code_next;
    hkt_pkg::code_t    modifier_reg;
    hkt_pkg::code_t    modifier_next;
    logic              found_reg;
    logic              found_next;
    logic              free_found_reg;
    logic              free_found_next;
    logic [IDX_W-1:0]  ins_idx_reg;
    logic [IDX_W-1:0]  ins_idx_next;
    logic [hkt_pkg::COUNT_W-1:0] count_reg;
    logic [hkt_pkg::COUNT_W-1:0] count_next;
    logic              key_down_reg;
    logic              key_down_next;
    hkt_pkg::code_t    report_reg  [hkt_pkg::REPORT_KEYS];
    hkt_pkg::code_t    report_next [hkt_pkg::REPORT_KEYS];

    hkt_pkg::code_t    slot_q [SLOT_COUNT];
    hkt_pkg::code_t    head;
    hkt_pkg::code_t    new_val;
    logic              shift;
    logic              last_step;
    logic              evt_beat;
    logic              rpt_beat;

    // Ring of slot cells: each cell takes its upper neighbour, and the last cell
    // takes the (possibly rewritten) head value, so a full lap restores the order.
    for (genvar i = 0; i < SLOT_COUNT; i++)
    begin : g_cell
        hkt_pkg::code_t cell_din;

        if (i == SLOT_COUNT - 1)
        begin : g_tail
            assign cell_din = new_val;
        end
        else
        begin : g_body
            assign cell_din = slot_q[i+1];
        end

        hkt_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .shift (shift),
            .din   (cell_din),
            .dout  (slot_q[i])
        );
    end

    assign head      = slot_q[0];
    assign last_step = (step_reg == LAST_IDX);
    assign evt_beat  = evt.valid && evt.ready;
    assign rpt_beat  = rpt.valid && rpt.ready;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            hkt_pkg::ST_IDLE:
            begin
                if (evt_beat)
                begin
                    state_next = hkt_pkg::ST_SCAN;
                end
            end
            hkt_pkg::ST_SCAN:
            begin
                if (last_step)
                begin
                    state_next = hkt_pkg::ST_UPDATE;
                end
            end
            hkt_pkg::ST_UPDATE:
            begin
                if (last_step)
                begin
                    state_next = hkt_pkg::ST_DONE;
                end
            end
            hkt_pkg::ST_DONE:
            begin
                if (rpt_beat)
                begin
                    state_next = hkt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = hkt_pkg::ST_IDLE;
            end
        endcase
    end

    // State decoded outputs.
    always_comb
    begin
        evt.ready = 1'b0;
        rpt.valid = 1'b0;
        shift     = 1'b0;
        case (state_reg)
            hkt_pkg::ST_IDLE:   evt.ready = 1'b1;
            hkt_pkg::ST_SCAN:   shift     = 1'b1;
            hkt_pkg::ST_UPDATE: shift     = 1'b1;
            hkt_pkg::ST_DONE:   rpt.valid = 1'b1;
            default:            shift     = 1'b0;
        endcase
    end

    // Value written back into the ring during the update lap. A release clears a
    // matching slot; a press that found no copy of its code lands in the first
    // empty slot seen during the scan lap.
    always_comb
    begin
        new_val = head;
        if (state_reg == hkt_pkg::ST_UPDATE && hkt_pkg::code_valid(code_reg))
        begin
            if (kind_reg == hkt_pkg::KIND_RELEASE && head == code_reg)
            begin
                new_val = '0;
            end
            else if (kind_reg == hkt_pkg::KIND_PRESS && !found_reg && free_found_reg
                     && step_reg == ins_idx_reg)
            begin
                new_val = code_reg;
            end
        end
    end

    // Datapath next values.
    always_comb
    begin
        step_next       = step_reg;
        kind_next       = kind_reg;
        code_next       = code_reg;
        modifier_next   = modifier_reg;
        found_next      = found_reg;
        free_found_next = free_found_reg;
        ins_idx_next    = ins_idx_reg;
        count_next      = count_reg;
        key_down_next   = key_down_reg;
        report_next     = report_reg;

        case (state_reg)
            hkt_pkg::ST_IDLE:
            begin
                if (evt_beat)
                begin
                    kind_next       = evt.kind;
                    code_next       = evt.key_usage;
                    step_next       = '0;
                    found_next      = 1'b0;
                    free_found_next = 1'b0;
                    if (evt.kind == hkt_pkg::KIND_SET_MODS)
                    begin
                        modifier_next = evt.modifier_bits;
                    end
                end
            end
            hkt_pkg::ST_SCAN:
            begin
                if (head == code_reg)
                begin
                    found_next = 1'b1;
                end
                if (!hkt_pkg::code_valid(head) && !free_found_reg)
                begin
                    free_found_next = 1'b1;
                    ins_idx_next    = step_reg;
                end
                if (last_step)
                begin
                    step_next     = '0;
                    count_next    = '0;
                    key_down_next = 1'b0;
                    for (int k = 0; k < hkt_pkg::REPORT_KEYS; k++)
                    begin
                        report_next[k] = '0;
                    end
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            hkt_pkg::ST_UPDATE:
            begin
                if (hkt_pkg::code_valid(new_val))
                begin
                    report_next[count_reg[hkt_pkg::REPORT_IDX_W-1:0]] = new_val;
                    count_next = count_reg + 1'b1;
                    if (new_val == code_reg)
                    begin
                        key_down_next = 1'b1;
                    end
                end
                if (!last_step)
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            default:
            begin
                step_next = step_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= hkt_pkg::ST_IDLE;
            step_reg       <= '0;
            modifier_reg   <= '0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            ins_idx_reg    <= '0;
            count_reg      <= '0;
            key_down_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            step_reg       <= step_next;
            modifier_reg   <= modifier_next;
            found_reg      <= found_next;
            free_found_reg <= free_found_next;
            ins_idx_reg    <= ins_idx_next;
            count_reg      <= count_next;
            key_down_reg   <= key_down_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        code_reg   <= code_next;
        report_reg <= report_next;
    end

    assign rpt.key_down       = key_down_reg;
    assign rpt.held_count     = count_reg;
    assign rpt.held_key_0     = report_reg[0];
    assign rpt.held_key_1     = report_reg[1];
    assign rpt.held_key_2     = report_reg[2];
    assign rpt.held_key_3     = report_reg[3];
    assign rpt.held_key_4     = report_reg[4];
    assign rpt.held_key_5     = report_reg[5];
    assign rpt.modifier_state = modifier_reg;

endmodule

@@ rtl/hkt_checker.sv @@
// Port-level checks for the held key table, bound to the top level.
module hkt_checker #(
    parameter int SLOT_COUNT = 6
) (
    input logic       clk,
    input logic       rst_n,
    input logic       evt_valid,
    input logic       evt_ready,
    input logic       rpt_valid,
    input logic       rpt_ready,
    input logic       key_down,
    input logic [2:0] held_count,
    input logic [7:0] held_key_0
);

    // A pending report beat stays offered until it is taken.
    a_rpt_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rpt_valid && !rpt_ready |=> rpt_valid)
        else $error("report beat withdrawn before it was taken");

    // The block never takes an event while a report is waiting.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(evt_ready && rpt_valid))
        else $error("event accepted while a report was pending");

    // The report cannot appear on the cycle straight after an event beat.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && evt_ready |=> !rpt_valid)
        else $error("report offered too early");

    // The packed count never exceeds the number of slots.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        rpt_valid |-> held_count <= 3'(SLOT_COUNT))
        else $error("held count beyond slot count");

    // A held key implies a non-empty report with a valid first code.
    a_key_down_count: assert property (@(posedge clk) disable iff (!rst_n)
        rpt_valid && key_down |-> held_count != 3'd0 && held_key_0 > 8'd3)
        else $error("key reported held in an empty report");

endmodule

bind held_key_table_core hkt_checker #(.SLOT_COUNT(SLOT_COUNT)) u_hkt_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .evt_valid  (evt.valid),
    .evt_ready  (evt.ready),
    .rpt_valid  (rpt.valid),
    .rpt_ready  (rpt.ready),
    .key_down   (rpt.key_down),
    .held_count (rpt.held_count),
    .held_key_0 (rpt.held_key_0)
);

@@ tb/sv/held_key_checker.sv @@
// Checker for the held key table: predicts every report beat and compares it field by field.
module held_key_checker #(
    parameter int SLOT_COUNT = 6
) (
    input  logic clk,
    input  logic rst_n,
    hkt_evt_if   evt,
    hkt_rpt_if   rpt,
    output int   failures,
    output int   pending
);

    typedef struct packed {
        logic                                          key_down;
        logic [hkt_pkg::COUNT_W-1:0]                   held_count;
        hkt_pkg::code_t [hkt_pkg::REPORT_KEYS-1:0]     held_keys;
        hkt_pkg::code_t                                modifier_state;
    } key_report_t;

    // Shadow copy of the slot table and modifier byte.
    hkt_pkg::code_t slot_table [SLOT_COUNT];
    hkt_pkg::code_t modifier_byte;
    key_report_t    expected_reports [$];

    initial failures = 0;

    // Applies one event to the shadow table and returns the report it should produce.
    function automatic key_report_t predict_report(input hkt_pkg::kind_t kind,
                                                   input hkt_pkg::code_t code,
                                                   input hkt_pkg::code_t mods);
        key_report_t rep;
        logic        code_ok;
        logic        already_held;
        logic        placed;
        int          n;
        code_ok      = code > hkt_pkg::LAST_INVALID_CODE;
        already_held = 1'b0;
        placed       = 1'b0;
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            if (code_ok && slot_table[i] == code)
                already_held = 1'b1;
        end
        case (kind)
            hkt_pkg::KIND_PRESS:
            begin
                if (code_ok && !already_held)
                begin
                    for (int i = 0; i < SLOT_COUNT; i++)
                    begin
                        if (!placed && slot_table[i] <= hkt_pkg::LAST_INVALID_CODE)
                        begin
                            slot_table[i] = code;
                            placed        = 1'b1;
                        end
                    end
                end
            end
            hkt_pkg::KIND_RELEASE:
            begin
                if (code_ok)
                begin
                    for (int i = 0; i < SLOT_COUNT; i++)
                    begin
                        if (slot_table[i] == code)
                            slot_table[i] = '0;
                    end
                end
            end
            hkt_pkg::KIND_SET_MODS: modifier_byte = mods;
            default: ;
        endcase
        rep = '0;
        n   = 0;
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            if (slot_table[i] > hkt_pkg::LAST_INVALID_CODE)
            begin
                if (code_ok && slot_table[i] == code)
                    rep.key_down = 1'b1;
                if (n < hkt_pkg::REPORT_KEYS)
                begin
                    rep.held_keys[n] = slot_table[i];
                    n++;
                end
            end
        end
        rep.held_count     = n[hkt_pkg::COUNT_W-1:0];
        rep.modifier_state = modifier_byte;
        return rep;
    endfunction

    task automatic report_failure(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        failures++;
    endtask

    task automatic check_field(input string what, input int unsigned want,
                               input int unsigned got);
        if (want != got)
            report_failure($sformatf("%s expected 0x%0h, got 0x%0h", what, want, got));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        key_report_t want;
        key_report_t got;
        if (!rst_n)
        begin
            for (int i = 0; i < SLOT_COUNT; i++)
                slot_table[i] = '0;
            modifier_byte = '0;
            expected_reports.delete();
            pending <= 0;
        end
        else
        begin
            // The report side is handled first so that the oldest prediction is used.
            if (rpt.valid && rpt.ready)
            begin
                got.key_down       = rpt.key_down;
                got.held_count     = rpt.held_count;
                got.held_keys      = {rpt.held_key_5, rpt.held_key_4, rpt.held_key_3,
                                      rpt.held_key_2, rpt.held_key_1, rpt.held_key_0};
                got.modifier_state = rpt.modifier_state;
                if (expected_reports.size() == 0)
                    report_failure("report beat arrived with no event outstanding");
                else
                begin
                    want = expected_reports.pop_front();
                    check_field("key_down", want.key_down, got.key_down);
                    check_field("held_count", want.held_count, got.held_count);
                    for (int i = 0; i < hkt_pkg::REPORT_KEYS; i++)
                        check_field($sformatf("held_key_%0d", i), want.held_keys[i],
                                    got.held_keys[i]);
                    check_field("modifier_state", want.modifier_state, got.modifier_state);
                end
            end
            if (evt.valid && evt.ready)
                expected_reports.push_back(predict_report(evt.kind, evt.key_usage,
                                                          evt.modifier_bits));
            pending <= expected_reports.size();
        end
    end

endmodule

@@ tb/sv/tb_held_key_table_core.sv @@
// Top of the held key table testbench: clock, reset, event stimulus, report back-pressure.
module tb_held_key_table_core;

    localparam int SLOT_COUNT     = 6;
    // Random events are sent in blocks; the events of each block share one small pool of key codes.
    localparam int BLOCK_EVENTS   = 50;
    localparam int RANDOM_BLOCKS  = 24;
    localparam int HOLDOFF_CYCLES = 250;
    // One event takes two laps of the slot ring before its report is offered.
    localparam int DRAIN_CYCLES   = 2 * SLOT_COUNT + 12;
    // Watchdog limit on the run length, with ample margin over the slowest correct run.
    localparam int CYCLE_LIMIT    = 600000;

    logic clk;
    logic rst_n;
    int   failures;
    int   pending;
    int   cycle_count;
    bit   holdoff_req;
    bit   sender_bursting;

    hkt_evt_if evt();
    hkt_rpt_if rpt();

    held_key_table_core #(.SLOT_COUNT(SLOT_COUNT)) dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .evt   (evt),
        .rpt   (rpt)
    );

    held_key_checker #(.SLOT_COUNT(SLOT_COUNT)) report_check
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .evt      (evt),
        .rpt      (rpt),
        .failures (failures),
        .pending  (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: if the run has not finished by the limit, something has hung.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

    // Receiver side. Ready is held for a run of cycles and then chosen afresh. Most
    // stalls are short, a few are long, and now and then there is a long stall-free
    // stretch. When the stimulus asks for a hold-off, ready stays low for HOLDOFF_CYCLES,
    // counted here, so the block fills and must refuse events.
    initial
    begin
        int run;
        int pick;
        forever
        begin
            if (holdoff_req)
            begin
                holdoff_req = 1'b0;
                rpt.ready <= 1'b0;
                run = HOLDOFF_CYCLES;
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 10)
                begin
                    rpt.ready <= 1'b1;
                    run = $urandom_range(100, 200);
                end
                else if (pick < 60)
                begin
                    rpt.ready <= 1'b1;
                    run = $urandom_range(1, 6);
                end
                else
                begin
                    rpt.ready <= 1'b0;
                    pick = $urandom_range(0, 99);
                    if (pick < 85)
                        run = $urandom_range(1, 3);
                    else if (pick < 98)
                        run = $urandom_range(4, 12);
                    else
                        run = $urandom_range(20, 60);
                end
            end
            repeat (run) @(posedge clk);
        end
    end

    // Idle gap after an accepted beat. While valid is low the payload lines carry
    // noise, which the block must ignore. In a burst the sender never idles.
    task automatic pause_sender();
        int gap;
        int pick;
        pick = $urandom_range(0, 99);
        if (sender_bursting || pick < 55)
            gap = 0;
        else if (pick < 88)
            gap = $urandom_range(1, 3);
        else if (pick < 98)
            gap = $urandom_range(4, 15);
        else
            gap = $urandom_range(20, 50);
        if (gap > 0)
        begin
            evt.valid         <= 1'b0;
            evt.kind          <= hkt_pkg::kind_t'($urandom_range(0, 3));
            evt.key_usage     <= 8'($urandom);
            evt.modifier_bits <= 8'($urandom);
            repeat (gap) @(posedge clk);
        end
    endtask

    // Offers one event beat and waits for the block to take it. Ready is sampled
    // just after the edge, so it is the value the edge itself saw.
    task automatic send_event(input hkt_pkg::kind_t kind, input hkt_pkg::code_t code,
                              input hkt_pkg::code_t mods);
        evt.valid         <= 1'b1;
        evt.kind          <= kind;
        evt.key_usage     <= code;
        evt.modifier_bits <= mods;
        do
            @(posedge clk);
        while (!evt.ready);
        pause_sender();
    endtask

    // Stops offering and waits until every outstanding report has been taken.
    task automatic wait_drained();
        evt.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    // Random event. Most codes come from a small pool so that presses collide with
    // held codes and the table fills; the rest are invalid codes or any byte at all.
    task automatic send_random_event(input int base, input int span);
        int             pick;
        hkt_pkg::kind_t kind;
        hkt_pkg::code_t code;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            kind = hkt_pkg::KIND_PRESS;
        else if (pick < 70)
            kind = hkt_pkg::KIND_RELEASE;
        else if (pick < 85)
            kind = hkt_pkg::KIND_QUERY;
        else
            kind = hkt_pkg::KIND_SET_MODS;
        pick = $urandom_range(0, 99);
        if (pick < 75)
            code = hkt_pkg::code_t'(base + $urandom_range(0, span - 1));
        else if (pick < 85)
            code = hkt_pkg::code_t'($urandom_range(0, int'(hkt_pkg::LAST_INVALID_CODE)));
        else
            code = 8'($urandom);
        send_event(kind, code, 8'($urandom));
    endtask

    initial
    begin
        int base;
        int span;
        holdoff_req       = 1'b0;
        sender_bursting   = 1'b0;
        evt.valid         <= 1'b0;
        evt.kind          <= hkt_pkg::KIND_QUERY;
        evt.key_usage     <= '0;
        evt.modifier_bits <= '0;
        rst_n             <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. An empty table is queried, and invalid codes are pressed
        // with a modifier byte that must be ignored.
        send_event(hkt_pkg::KIND_QUERY, 8'd0, 8'h00);
        send_event(hkt_pkg::KIND_PRESS, 8'd3, 8'hAA);
        send_event(hkt_pkg::KIND_PRESS, 8'd0, 8'h55);
        // Fill the table with the lowest and highest valid codes among others,
        // pressing one of them twice on the way.
        send_event(hkt_pkg::KIND_PRESS, 8'd4, 8'hFF);
        send_event(hkt_pkg::KIND_PRESS, 8'd255, 8'h00);
        send_event(hkt_pkg::KIND_PRESS, 8'd4, 8'h00);
        send_event(hkt_pkg::KIND_PRESS, 8'h80, 8'h00);
        send_event(hkt_pkg::KIND_PRESS, 8'h7F, 8'h00);
        send_event(hkt_pkg::KIND_PRESS, 8'h55, 8'h00);
        send_event(hkt_pkg::KIND_PRESS, 8'h2A, 8'h00);
        // The table is now full, so this press is dropped.
        send_event(hkt_pkg::KIND_PRESS, 8'h33, 8'h00);
        // Emptying a middle slot must pack the report and let the next press in there.
        send_event(hkt_pkg::KIND_RELEASE, 8'd255, 8'h00);
        send_event(hkt_pkg::KIND_RELEASE, 8'h33, 8'h00);
        send_event(hkt_pkg::KIND_QUERY, 8'd4, 8'h00);
        send_event(hkt_pkg::KIND_PRESS, 8'h33, 8'h00);
        send_event(hkt_pkg::KIND_RELEASE, 8'd3, 8'h00);
        send_event(hkt_pkg::KIND_SET_MODS, 8'd4, 8'hFF);
        send_event(hkt_pkg::KIND_SET_MODS, 8'd0, 8'h00);
        send_event(hkt_pkg::KIND_SET_MODS, 8'h33, 8'hA5);
        send_event(hkt_pkg::KIND_RELEASE, 8'd4, 8'h00);
        send_event(hkt_pkg::KIND_RELEASE, 8'h33, 8'h00);
        send_event(hkt_pkg::KIND_RELEASE, 8'h80, 8'h00);
        send_event(hkt_pkg::KIND_RELEASE, 8'h7F, 8'h00);
        send_event(hkt_pkg::KIND_RELEASE, 8'h55, 8'h00);
        send_event(hkt_pkg::KIND_RELEASE, 8'h2A, 8'h00);
        wait_drained();

        // Random part. Each block draws a fresh pool of neighbouring codes and
        // decides whether the sender runs without gaps.
        for (int blk = 0; blk < RANDOM_BLOCKS; blk++)
        begin
            sender_bursting = ($urandom_range(0, 3) == 0);
            span = $urandom_range(3, 10);
            base = $urandom_range(int'(hkt_pkg::LAST_INVALID_CODE) + 1, 256 - span);
            // In this block the receiver holds off for a long stretch while the
            // sender keeps offering beats back to back.
            if (blk == RANDOM_BLOCKS / 3)
            begin
                sender_bursting = 1'b1;
                holdoff_req     = 1'b1;
            end
            for (int n = 0; n < BLOCK_EVENTS; n++)
                send_random_event(base, span);
            // Now and then, and once for certain, the sender waits for every report.
            if (blk == 2 * RANDOM_BLOCKS / 3 || $urandom_range(0, 7) == 0)
                wait_drained();
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
